FILE: hw/rtl/serial_motor_command_pulser_unit_macros.svh
// Assertion macros shared by the serial motor command pulser RTL.
`ifndef SERIAL_MOTOR_COMMAND_PULSER_UNIT_MACROS_SVH
`define SERIAL_MOTOR_COMMAND_PULSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define SMCP_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SMCP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SMCP_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define SMCP_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/smcp_pkg.sv
// Package with constants and types for the serial motor command pulser.
`default_nettype none

package smcp_pkg;

   // Frame layout
   localparam int unsigned FRAME_LEN = 8;
   localparam int unsigned POS_W     = 3;
   localparam logic [POS_W-1:0] POS_AXIS   = 3'd0;
   localparam logic [POS_W-1:0] POS_SEP1   = 3'd1;
   localparam logic [POS_W-1:0] POS_DIR    = 3'd2;
   localparam logic [POS_W-1:0] POS_SEP2   = 3'd3;
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

   // Field widths
   localparam int unsigned TICKS_W = 16;
   localparam int unsigned DUR_W   = 14;
   localparam int unsigned DRIVE_W = 4;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd10;

   // Characters
   localparam logic [7:0] CHAR_X        = 8'h78;
   localparam logic [7:0] CHAR_Y        = 8'h79;
   localparam logic [7:0] CHAR_F        = 8'h66;
   localparam logic [7:0] CHAR_B        = 8'h62;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_BELOW_0  = 8'h2F;
   localparam logic [7:0] CHAR_ABOVE_9  = 8'h3A;

   // Item codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Motor output codes
   localparam logic [DRIVE_W-1:0] DRIVE_OFF = 4'b0000;
   localparam logic [DRIVE_W-1:0] DRIVE_XF  = 4'b1000;
   localparam logic [DRIVE_W-1:0] DRIVE_XB  = 4'b0100;
   localparam logic [DRIVE_W-1:0] DRIVE_YF  = 4'b0010;
   localparam logic [DRIVE_W-1:0] DRIVE_YB  = 4'b0001;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic               prompt;
      logic               accepted;
      logic               rejected;
   } smcp_result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/smcp_core.sv
// Frame parser and pulse timer: state update and result for one beat.
`default_nettype none

module smcp_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            take,
   input  wire logic                            cmd,
   input  wire logic [7:0]                      rx_byte,
   input  wire logic                            csr_write_enable,
   input  wire logic [smcp_pkg::TICKS_W-1:0]    csr_write_data,
   output smcp_pkg::smcp_result_type            result
);
   import smcp_pkg::*;

   logic [TICKS_W-1:0] ticks_per_unit_ff;
   logic [POS_W-1:0]   byte_position_ff, byte_position_in;
   logic               frame_valid_ff, frame_valid_in;
   logic               axis_is_y_ff, axis_is_y_in;
   logic               dir_is_back_ff, dir_is_back_in;
   logic [DUR_W-1:0]   duration_acc_ff, duration_acc_in;
   logic               pulse_active_ff, pulse_active_in;
   logic [DUR_W-1:0]   units_left_ff, units_left_in;
   logic [TICKS_W-1:0] tick_count_ff, tick_count_in;
   logic               first_item_ff, first_item_in;
   logic [DRIVE_W-1:0] drive_reg_ff, drive_reg_in;

   logic [TICKS_W-1:0] tick_limit;
   logic [TICKS_W-1:0] tick_next;
   logic [DUR_W-1:0]   units_next;
   logic               is_digit;
   logic [DUR_W-1:0]   acc_times_ten;
   logic               prompt;
   logic               accepted;
   logic               rejected;

   // Treat a zero unit length as one tick
   assign tick_limit = (ticks_per_unit_ff == '0) ? TICKS_W'(1) : ticks_per_unit_ff;
   assign tick_next  = tick_count_ff + TICKS_W'(1);
   assign units_next = (units_left_ff != '0) ? units_left_ff - DUR_W'(1) : units_left_ff;

   // Multiply by ten as two shifts and an add
   assign is_digit      = (rx_byte > CHAR_BELOW_0) && (rx_byte < CHAR_ABOVE_9);
   assign acc_times_ten = {duration_acc_ff[DUR_W-4:0], 3'b000}
                        + {duration_acc_ff[DUR_W-2:0], 1'b0};

   // Advance parser and timer state for the accepted beat
   always_comb begin
      byte_position_in = byte_position_ff;
      frame_valid_in   = frame_valid_ff;
      axis_is_y_in     = axis_is_y_ff;
      dir_is_back_in   = dir_is_back_ff;
      duration_acc_in  = duration_acc_ff;
      pulse_active_in  = pulse_active_ff;
      units_left_in    = units_left_ff;
      tick_count_in    = tick_count_ff;
      first_item_in    = first_item_ff;
      drive_reg_in     = drive_reg_ff;
      prompt           = 1'b0;
      accepted         = 1'b0;
      rejected         = 1'b0;

      if (take) begin
         if (first_item_ff) begin
            prompt        = 1'b1;
            first_item_in = 1'b0;
         end

         if (cmd == CMD_TICK) begin
            // Count ticks only while a pulse runs
            if (pulse_active_ff) begin
               tick_count_in = tick_next;
               if (tick_next >= tick_limit) begin
                  tick_count_in = '0;
                  units_left_in = units_next;
                  if (units_next == '0) begin
                     pulse_active_in = 1'b0;
                     drive_reg_in    = DRIVE_OFF;
                     prompt          = 1'b1;
                  end
               end
            end
         end else if (!pulse_active_ff) begin
            // Check the byte against its place in the frame
            case (byte_position_ff)
               POS_AXIS: begin
                  if (rx_byte == CHAR_X) begin
                     axis_is_y_in = 1'b0;
                  end else if (rx_byte == CHAR_Y) begin
                     axis_is_y_in = 1'b1;
                  end else begin
                     frame_valid_in = 1'b0;
                  end
               end
               POS_SEP1, POS_SEP2: begin
                  if (rx_byte != CHAR_COLON) begin
                     frame_valid_in = 1'b0;
                  end
               end
               POS_DIR: begin
                  if (rx_byte == CHAR_F) begin
                     dir_is_back_in = 1'b0;
                  end else if (rx_byte == CHAR_B) begin
                     dir_is_back_in = 1'b1;
                  end else begin
                     frame_valid_in = 1'b0;
                  end
               end
               default: begin
                  if (is_digit) begin
                     duration_acc_in = acc_times_ten + {{(DUR_W-4){1'b0}}, rx_byte[3:0]};
                  end else begin
                     frame_valid_in = 1'b0;
                  end
               end
            endcase

            // Close the frame on its last byte
            if (byte_position_ff == POS_LAST) begin
               if (frame_valid_in) begin
                  accepted = 1'b1;
                  if (duration_acc_in != '0) begin
                     case ({axis_is_y_in, dir_is_back_in})
                        2'b00:   drive_reg_in = DRIVE_XF;
                        2'b01:   drive_reg_in = DRIVE_XB;
                        2'b10:   drive_reg_in = DRIVE_YF;
                        default: drive_reg_in = DRIVE_YB;
                     endcase
                     units_left_in   = duration_acc_in;
                     tick_count_in   = '0;
                     pulse_active_in = 1'b1;
                  end else begin
                     prompt = 1'b1;
                  end
               end else begin
                  rejected = 1'b1;
                  prompt   = 1'b1;
               end
               byte_position_in = '0;
               frame_valid_in   = 1'b1;
               duration_acc_in  = '0;
            end else begin
               byte_position_in = byte_position_ff + POS_W'(1);
            end
         end
      end
   end

   // Drive the result of this beat
   always_comb begin
      result.drive    = drive_reg_in;
      result.prompt   = prompt;
      result.accepted = accepted;
      result.rejected = rejected;
   end

   // Hold state between beats
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_unit_ff <= TICKS_RESET;
         byte_position_ff  <= '0;
         frame_valid_ff    <= 1'b1;
         axis_is_y_ff      <= 1'b0;
         dir_is_back_ff    <= 1'b0;
         duration_acc_ff   <= '0;
         pulse_active_ff   <= 1'b0;
         units_left_ff     <= '0;
         tick_count_ff     <= '0;
         first_item_ff     <= 1'b1;
         drive_reg_ff      <= DRIVE_OFF;
      end else begin
         if (csr_write_enable) begin
            ticks_per_unit_ff <= csr_write_data;
         end
         byte_position_ff <= byte_position_in;
         frame_valid_ff   <= frame_valid_in;
         axis_is_y_ff     <= axis_is_y_in;
         dir_is_back_ff   <= dir_is_back_in;
         duration_acc_ff  <= duration_acc_in;
         pulse_active_ff  <= pulse_active_in;
         units_left_ff    <= units_left_in;
         tick_count_ff    <= tick_count_in;
         first_item_ff    <= first_item_in;
         drive_reg_ff     <= drive_reg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/serial_motor_command_pulser_unit.sv
// Top level of the serial motor command pulser: input handshake and result buffering.
//
// Usage:
//  - req channel carries one beat per item: req_cmd 0 = received byte in req_rx_byte,
//    req_cmd 1 = one time tick. Frames are "a:d:nnnn" with axis x/y, direction f/b
//    and a four-digit decimal duration.
//  - rsp channel returns exactly one beat per req beat, in order: the motor outputs
//    after that item, the prompt strobe and the accepted/rejected flags.
//  - csr port writes ticks_per_unit (ticks per duration unit); write it
//    only while no results are outstanding.
//  - Each result is registered before it is valid on rsp (via the skid when stalled).
//  - Throughput: one item per cycle while req_ready is high; the parser and timer
//    update is a single pass of compare and shift-add logic between the state
//    registers and the result register.
//  - Stall: a two-entry result buffer (output register plus skid register) lets one
//    more item in while rsp_ready is low; req_ready drops once the skid is full.
//  - Reset: clears the buffer, sets ticks_per_unit to 10, stops any pulse and arms
//    the prompt for the first item.
`default_nettype none

module serial_motor_command_pulser_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_cmd,
   input  wire logic [7:0]                      req_rx_byte,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [smcp_pkg::DRIVE_W-1:0]    rsp_drive,
   output      logic                            rsp_prompt,
   output      logic                            rsp_accepted,
   output      logic                            rsp_rejected,
   input  wire logic                            csr_write_enable,
   input  wire logic [smcp_pkg::TICKS_W-1:0]    csr_write_data
);
   import smcp_pkg::*;

   `include "serial_motor_command_pulser_unit_macros.svh"

   logic            take;
   logic            out_free;
   smcp_result_type core_result;
   smcp_result_type out_ff, out_in;
   smcp_result_type skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;

   assign req_ready = !skid_valid_ff;
   assign take      = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   smcp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .cmd              (req_cmd),
      .rx_byte          (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (core_result)
   );

   // Route the new result to the output register or the skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = core_result;
            skid_valid_in = take;
         end else begin
            out_in       = core_result;
            out_valid_in = take;
         end
      end else if (take) begin
         skid_in       = core_result;
         skid_valid_in = 1'b1;
      end
   end

   // Hold buffer payload; clear only the valid flags at reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_drive    = out_ff.drive;
   assign rsp_prompt   = out_ff.prompt;
   assign rsp_accepted = out_ff.accepted;
   assign rsp_rejected = out_ff.rejected;

   // A frame ends either accepted or rejected, never both
   `SMCP_ASSERT_IMPLY(a_acc_rej_excl, clock, reset, rsp_valid,
      !(rsp_accepted && rsp_rejected), "accepted and rejected both set")

   // At most one motor output is on
   `SMCP_ASSERT_IMPLY(a_drive_onehot, clock, reset, rsp_valid,
      $onehot0(rsp_drive), "more than one motor output on")

   // A rejected frame always prompts and leaves the motors off
   `SMCP_ASSERT_IMPLY(a_rej_prompt, clock, reset, rsp_valid && rsp_rejected,
      rsp_prompt && (rsp_drive == DRIVE_OFF), "rejected frame without prompt")

   // The skid stage fills only behind a waiting output beat
   `SMCP_ASSERT_IMPLY(a_skid_order, clock, reset, skid_valid_ff,
      out_valid_ff, "skid holds a beat while output is empty")

   // A stalled skid keeps the input side closed in the next cycle
   `SMCP_ASSERT_NEXT(a_skid_hold, clock, reset, skid_valid_ff && !rsp_ready,
      !req_ready, "input opened while result buffer full")

endmodule

`default_nettype wire
